FILE: rtl/core/stre_pkg.sv
// ----------------------------------------------------------------------------
// stre_pkg
// Shared types and constants of the sprite tile row expander.
// ----------------------------------------------------------------------------
package stre_pkg;

  localparam int MAX_SPRITE_BLOCKS = 16;

  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [1:0] ACT_FRAME  = 2'd0;
  localparam logic [1:0] ACT_PASS   = 2'd1;
  localparam logic [1:0] ACT_SPRITE = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_SCROLL_X     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCROLL_Y     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_ENABLE = 2'd2;

  localparam logic [15:0] DEPTH_CLEAR_LIMIT = 16'hFC00;
  localparam logic signed [12:0] SCREEN_X_MAX = 13'sd383;
  localparam logic signed [12:0] SCREEN_Y_MAX = 13'sd223;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FRAME,
    ST_ROWS
  } stre_state_t;

  typedef enum logic [1:0] {
    V_DROP,
    V_FRAME,
    V_PASS,
    V_SPRITE
  } stre_verdict_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic load_frame;
    logic load_row;
  } stre_cmd_t;

  typedef struct packed {
    stre_verdict_t verdict;
    logic          out_free;
    logic          row_last;
  } stre_sts_t;

endpackage

FILE: rtl/core/stre_ctrl.sv
// ----------------------------------------------------------------------------
// stre_ctrl
// Sequencer: accept, evaluate, then emit the frame beat or the tile rows, or go back to idle.
// ----------------------------------------------------------------------------
module stre_ctrl import stre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  stre_sts_t sts,
  output stre_cmd_t cmd
);

  stre_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        case (sts.verdict)
          V_FRAME:  state_nxt = ST_FRAME;
          V_SPRITE: state_nxt = ST_ROWS;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_FRAME: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_ROWS: begin
        if (sts.out_free && sts.row_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_EVAL:  cmd.eval       = 1'b1;
      ST_FRAME: cmd.load_frame = sts.out_free;
      ST_ROWS:  cmd.load_row   = sts.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/stre_dp.sv
// ----------------------------------------------------------------------------
// stre_dp
// Datapath: config registers, depth bookkeeping, sprite decode, row builder
// and output register.
// ----------------------------------------------------------------------------
module stre_dp import stre_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  stre_cmd_t              cmd,
  output stre_sts_t              sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic [9:0]  scroll_x_r, scroll_y_r;
  logic [7:0]  level_enable_r;

  logic        mask_seen_r;
  logic [2:0]  level_from_r, level_to_r;
  logic [15:0] max_drawn_r, max_masked_r;

  logic [1:0]  act_r;
  logic [2:0]  in_from_r, in_to_r;
  logic [15:0] depth_r, wx_r, wy_r, wt_r, wa_r;

  logic signed [11:0] x_r, y_r;
  logic [17:0] tile_r;
  logic [4:0]  bx_r, by_r;
  logic        fx_r, fy_r, care_r, mdraw_r, clr_r;
  logic [4:0]  pal_r;
  logic [3:0]  dy_r;

  logic        out_valid_r;
  logic signed [11:0] o_x_r, o_y_r;
  logic [18:0] o_base_r;
  logic [3:0]  o_cs_r;
  logic [4:0]  o_cols_r, o_pal_r;
  logic        o_fx_r, o_care_r, o_mdraw_r, o_clr_r, o_last_r;

  // evaluation
  logic [2:0]  lvl;
  logic        depth_ok, lvl_en, set_mask;
  stre_verdict_t verdict;
  logic        frame_clr;
  logic [15:0] frame_off;
  logic        mdraw;
  logic [9:0]  wx_adj;
  logic signed [11:0] x_c, y_c;
  logic [4:0]  bx_raw, by_raw, bx_c, by_c;
  logic signed [12:0] x_end, y_end;
  logic        care;

  // row build
  logic [4:0]  ey5;
  logic [3:0]  ey;
  logic signed [11:0] row_y;
  logic [18:0] row_base;
  logic        row_last;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_x_r     <= '0;
      scroll_y_r     <= '0;
      level_enable_r <= 8'hFF;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_SCROLL_X:     scroll_x_r     <= cfg_wr_data;
        CFG_SCROLL_Y:     scroll_y_r     <= cfg_wr_data;
        CFG_LEVEL_ENABLE: level_enable_r <= cfg_wr_data[7:0];
        default:          scroll_x_r     <= scroll_x_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r     <= in_tuser;
      in_from_r <= in_tdata[2:0];
      in_to_r   <= in_tdata[5:3];
      depth_r   <= in_tdata[21:6];
      wx_r      <= in_tdata[37:22];
      wy_r      <= in_tdata[53:38];
      wt_r      <= in_tdata[69:54];
      wa_r      <= in_tdata[85:70];
    end
  end

  always_comb begin
    lvl      = wx_r[15:13];
    depth_ok = depth_r >= max_drawn_r;
    lvl_en   = level_enable_r[lvl];
    set_mask = 1'b0;
    case (act_r)
      ACT_FRAME: verdict = V_FRAME;
      ACT_PASS:  verdict = V_PASS;
      ACT_SPRITE: begin
        if (!depth_ok || !lvl_en) begin
          verdict = V_DROP;
        end else if (lvl > level_to_r) begin
          verdict  = V_DROP;
          set_mask = 1'b1;
        end else if (lvl < level_from_r) begin
          verdict = V_DROP;
        end else begin
          verdict = V_SPRITE;
        end
      end
      default: verdict = V_DROP;
    endcase

    frame_clr = max_masked_r >= DEPTH_CLEAR_LIMIT;
    frame_off = frame_clr ? 16'd0 : max_masked_r;

    mdraw = mask_seen_r ? 1'b1 : (max_masked_r > depth_r);

    wx_adj = wa_r[7] ? (wx_r[9:0] + scroll_x_r) : wx_r[9:0];
    x_c    = {{2{wx_adj[9]}}, wx_adj} - {2'b00, scroll_x_r};
    y_c    = {{2{wy_r[9]}}, wy_r[9:0]} - {2'b00, scroll_y_r};

    bx_raw = {1'b0, wa_r[11:8]} + 5'd1;
    by_raw = {1'b0, wa_r[15:12]} + 5'd1;
    bx_c   = (bx_raw > 5'(MAX_SPRITE_BLOCKS)) ? 5'(MAX_SPRITE_BLOCKS) : bx_raw;
    by_c   = (by_raw > 5'(MAX_SPRITE_BLOCKS)) ? 5'(MAX_SPRITE_BLOCKS) : by_raw;

    x_end = {x_c[11], x_c} + $signed({4'b0000, bx_c, 4'b0000});
    y_end = {y_c[11], y_c} + $signed({4'b0000, by_c, 4'b0000});
    care  = x_c[11] || y_c[11] || (x_end > SCREEN_X_MAX) || (y_end > SCREEN_Y_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_seen_r  <= 1'b0;
      level_from_r <= 3'd0;
      level_to_r   <= 3'd7;
      max_drawn_r  <= 16'd1;
      max_masked_r <= 16'd0;
    end else if (cmd.eval) begin
      case (verdict)
        V_FRAME: begin
          max_drawn_r  <= frame_off + 16'd1;
          max_masked_r <= frame_off;
        end
        V_PASS: begin
          level_from_r <= in_from_r;
          level_to_r   <= in_to_r;
          mask_seen_r  <= 1'b0;
        end
        V_SPRITE: begin
          if (mask_seen_r) max_masked_r <= depth_r;
          else             max_drawn_r  <= depth_r;
        end
        default: begin
          if (set_mask) mask_seen_r <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      clr_r   <= frame_clr;
      x_r     <= x_c;
      y_r     <= y_c;
      tile_r  <= {wy_r[14:13], wt_r};
      bx_r    <= bx_c;
      by_r    <= by_c;
      fx_r    <= wa_r[5];
      fy_r    <= wa_r[6];
      pal_r   <= wa_r[4:0];
      care_r  <= care;
      mdraw_r <= mdraw;
      dy_r    <= '0;
    end else if (cmd.load_row) begin
      dy_r <= dy_r + 4'd1;
    end
  end

  always_comb begin
    ey5      = fy_r ? (by_r - 5'd1 - {1'b0, dy_r}) : {1'b0, dy_r};
    ey       = ey5[3:0];
    row_y    = y_r + $signed({4'b0000, ey, 4'b0000});
    row_base = {1'b0, tile_r[17:4], 4'b0000} + {11'd0, dy_r, 4'b0000};
    row_last = ({1'b0, dy_r} + 5'd1) == by_r;
    out_free = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_frame || cmd.load_row) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      o_x_r     <= '0;
      o_y_r     <= '0;
      o_base_r  <= '0;
      o_cs_r    <= '0;
      o_cols_r  <= '0;
      o_fx_r    <= 1'b0;
      o_pal_r   <= '0;
      o_care_r  <= 1'b0;
      o_mdraw_r <= 1'b0;
      o_clr_r   <= clr_r;
      o_last_r  <= 1'b1;
    end else if (cmd.load_row) begin
      o_x_r     <= x_r;
      o_y_r     <= row_y;
      o_base_r  <= row_base;
      o_cs_r    <= tile_r[3:0];
      o_cols_r  <= bx_r;
      o_fx_r    <= fx_r;
      o_pal_r   <= pal_r;
      o_care_r  <= care_r;
      o_mdraw_r <= mdraw_r;
      o_clr_r   <= 1'b0;
      o_last_r  <= row_last;
    end
  end

  assign sts.verdict  = verdict;
  assign sts.out_free = out_free;
  assign sts.row_last = row_last;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, o_mdraw_r, o_care_r, o_pal_r, o_fx_r, o_cols_r,
                       o_cs_r, o_base_r, o_y_r, o_x_r};
  assign out_tuser  = o_clr_r;
  assign out_tlast  = o_last_r;

endmodule

FILE: rtl/core/sprite_to_tile_row_expander_unit.sv
// ----------------------------------------------------------------------------
// sprite_to_tile_row_expander_unit
// Turns sprite attribute beats into one tile row beat per sprite row.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one beat per command; in_tuser selects frame start, pass start
//            or sprite attributes, in_tdata carries the pass range, depth and
//            the four attribute words.
//   out_*  : one beat per tile row of a drawn sprite, or one zero beat for
//            a frame start, with out_tuser set when it clears the depth;
//            out_tlast marks the final beat belonging to an input beat.
//   cfg_*  : scroll and level enable writes; the user must make them only
//            while the block is idle; the block itself does not enforce it.
// An input beat is captured, then evaluated in the cycle after. A sprite
// then emits its rows one per cycle while the output is not stalled,
// paced by the single row builder. A frame start emits one beat; pass
// starts and dropped sprites return to idle after evaluation.
// Reset clears the config registers and depth bookkeeping to their defaults
// and empties the output register. When out_tready is low the output beat
// holds and row generation pauses; the next input beat is still taken once
// the current one has handed its last result to the output register.
// ----------------------------------------------------------------------------
module sprite_to_tile_row_expander_unit import stre_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // level_from[2:0], level_to[5:3], depth_value[21:6], word_position_x[37:22],
  // word_position_y[53:38], word_tile[69:54], word_attributes[85:70], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // row_x[11:0], row_y[23:12], row_tile_base[42:24], column_start[46:43],
  // columns[51:47], flip_x[52], palette[57:53], edge_care[58],
  // use_mask_draw[59], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // clear_depth[0]
  output logic                   out_tuser,
  output logic                   out_tlast
);

  stre_cmd_t cmd;
  stre_sts_t sts;

  stre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stre_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

FILE: rtl/core/stre_checker.sv
// ----------------------------------------------------------------------------
// stre_checker
// Port-level checks of the sprite tile row expander.
// ----------------------------------------------------------------------------
module stre_checker import stre_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_frame_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("clear beat not a lone zero beat");

  a_row_cols: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && (out_tdata[51:47] != 5'd0) |->
      out_tdata[51:47] <= 5'(MAX_SPRITE_BLOCKS))
    else $error("row column count out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken before evaluation");

endmodule

bind sprite_to_tile_row_expander_unit stre_checker u_stre_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sprite tile row expander against a cycle-free predictor of its
// depth bookkeeping, level filter and row expansion. A directed sequence walks
// the depth order, pass ranges, frame clears, scroll and level enable; random
// frames of passes and sprites follow under several register settings, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;
  import stre_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [11:0] row_x;
    logic [11:0] row_y;
    logic [18:0] tile_base;
    logic [3:0]  col_start;
    logic [4:0]  columns;
    logic        flip_x;
    logic [4:0]  palette;
    logic        edge_care;
    logic        mask_draw;
    logic        clear_depth;
    logic        row_last;
  } tile_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  // predictor state and register copies
  logic [9:0]  obj_scroll_x;
  logic [9:0]  obj_scroll_y;
  logic [7:0]  level_mask;
  logic        pass_masked;
  logic [2:0]  pass_lo;
  logic [2:0]  pass_hi;
  logic [15:0] drawn_depth;
  logic [15:0] masked_depth;
  logic [15:0] depth_offset;

  tile_row_t expected_rows[$];
  int        mismatches = 0;
  int        items_sent = 0;
  logic      sender_calm = 1'b0;
  logic      receiver_calm = 1'b0;

  sprite_to_tile_row_expander_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [15:0] rand16();
    logic [31:0] v;
    v = $urandom;
    return v[15:0];
  endfunction

  task automatic report(input string what, input longint unsigned want, got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  task automatic compare_field(input string what, input longint unsigned want, got);
    if (want != got) report(what, want, got);
  endtask

  // Work out the tile rows one accepted beat causes and queue them.
  task automatic compute_tile_rows(input logic [1:0] action, input logic [2:0] lo, hi,
                                   input logic [15:0] depth, wx, wy, wt, wa);
    logic [2:0]  lvl;
    logic [15:0] wx_adj;
    logic [18:0] tile;
    logic        mdraw;
    logic        care;
    int          x;
    int          y;
    int          yy;
    int          bx;
    int          by;
    int          ey;
    tile_row_t   r;
    case (action)
      ACT_FRAME: begin
        r = '0;
        depth_offset = masked_depth;
        if (depth_offset >= DEPTH_CLEAR_LIMIT) begin
          depth_offset = 16'd0;
          r.clear_depth = 1'b1;
        end
        drawn_depth = depth_offset + 16'd1;
        masked_depth = depth_offset;
        r.row_last = 1'b1;
        expected_rows.push_back(r);
      end
      ACT_PASS: begin
        pass_lo = lo;
        pass_hi = hi;
        pass_masked = 1'b0;
      end
      ACT_SPRITE: begin
        lvl = wx[15:13];
        if (depth >= drawn_depth && level_mask[lvl]) begin
          if (lvl > pass_hi) begin
            pass_masked = 1'b1;
          end else if (lvl >= pass_lo) begin
            if (pass_masked) masked_depth = depth;
            else drawn_depth = depth;
            mdraw = pass_masked || (masked_depth > drawn_depth);
            wx_adj = wa[7] ? wx + {6'd0, obj_scroll_x} : wx;
            x = int'($signed(wx_adj[9:0])) - int'(obj_scroll_x);
            y = int'($signed(wy[9:0])) - int'(obj_scroll_y);
            tile = {1'b0, wy[14:13], wt};
            bx = int'(wa[11:8]) + 1;
            by = int'(wa[15:12]) + 1;
            if (bx > MAX_SPRITE_BLOCKS) bx = MAX_SPRITE_BLOCKS;
            if (by > MAX_SPRITE_BLOCKS) by = MAX_SPRITE_BLOCKS;
            care = (x < 0) || (y < 0) || (x + 16 * bx > SCREEN_X_MAX) ||
                   (y + 16 * by > SCREEN_Y_MAX);
            for (int dy = 0; dy < by; dy++) begin
              ey = wa[6] ? by - 1 - dy : dy;
              yy = y + 16 * ey;
              r = '0;
              r.row_x = x[11:0];
              r.row_y = yy[11:0];
              r.tile_base = {tile[18:4], 4'h0} + {dy[14:0], 4'h0};
              r.col_start = tile[3:0];
              r.columns = bx[4:0];
              r.flip_x = wa[5];
              r.palette = wa[4:0];
              r.edge_care = care;
              r.mask_draw = mdraw;
              r.row_last = (dy == by - 1);
              expected_rows.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [1:0] action, input logic [2:0] lo, hi,
                           input logic [15:0] depth, wx, wy, wt, wa);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tdata <= {2'b00, wa, wt, wy, wx, depth, hi, lo};
    do @(posedge clk); while (!in_tready);
    compute_tile_rows(action, lo, hi, depth, wx, wy, wt, wa);
    items_sent++;
  endtask

  task automatic frame_start();
    logic [15:0] n;
    n = rand16();
    send_beat(ACT_FRAME, n[2:0], n[5:3], rand16(), rand16(), rand16(), rand16(), rand16());
  endtask

  task automatic pass_start(input logic [2:0] lo, hi);
    send_beat(ACT_PASS, lo, hi, rand16(), rand16(), rand16(), rand16(), rand16());
  endtask

  task automatic sprite(input logic [15:0] depth, wx, wy, wt, wa);
    logic [15:0] n;
    n = rand16();
    send_beat(ACT_SPRITE, n[2:0], n[5:3], depth, wx, wy, wt, wa);
  endtask

  // Drop valid, drain every expected row, then let trailing work finish.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [9:0] sx, sy, input logic [7:0] en);
    logic [15:0] n;
    n = rand16();
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_SCROLL_X;
    cfg_wr_data <= sx;
    @(negedge clk);
    cfg_addr <= CFG_SCROLL_Y;
    cfg_wr_data <= sy;
    @(negedge clk);
    cfg_addr <= CFG_LEVEL_ENABLE;
    cfg_wr_data <= {n[1:0], en};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    obj_scroll_x = sx;
    obj_scroll_y = sy;
    level_mask = en;
  endtask

  task automatic test_depth_order();
    frame_start();
    sprite(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    sprite(16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    sprite(16'h0006, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    sprite(16'hFFFF, 16'h0200, 16'h0200, 16'h1234, 16'h0F3A);
    frame_start();
    pass_start(3'd2, 3'd4);
    sprite(16'h0010, {3'd1, 13'h0040}, 16'h0020, 16'h00A7, 16'h1101);
    sprite(16'h0011, {3'd5, 13'h0040}, 16'h0020, 16'h00A7, 16'h1101);
    sprite(16'h8000, {3'd3, 13'h0160}, 16'h00D0, 16'hBEEF, 16'h2355);
    pass_start(3'd2, 3'd4);
    sprite(16'h0100, {3'd2, 13'h0010}, 16'h0010, 16'h4321, 16'h0162);
    pass_start(3'd5, 3'd2);
    sprite(16'h0200, {3'd5, 13'h0010}, 16'h0010, 16'h4321, 16'h0162);
    sprite(16'h0201, {3'd2, 13'h0010}, 16'h0010, 16'h4321, 16'h0162);
    send_beat(ACT_UNUSED, 3'd0, 3'd7, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    pass_start(3'd0, 3'd3);
    sprite(16'hFC10, {3'd6, 13'h0010}, 16'h0010, 16'h0001, 16'h0000);
    sprite(16'hFD00, {3'd1, 13'h0010}, 16'h4010, 16'h0001, 16'h1000);
    frame_start();
    frame_start();
  endtask

  task automatic test_scroll_and_enable();
    set_config(10'h3FF, 10'h3FF, 8'h00);
    frame_start();
    sprite(16'h0010, {3'd1, 13'h0005}, 16'h0005, 16'h0033, 16'h0080);
    set_config(10'h3FF, 10'h3FF, 8'h5A);
    sprite(16'h0020, {3'd1, 13'h0005}, 16'h0005, 16'h0033, 16'h1180);
    sprite(16'h0021, {3'd4, 13'h0005}, 16'h0005, 16'h0033, 16'h1100);
    sprite(16'h0022, {3'd0, 13'h0005}, 16'h0005, 16'h0033, 16'h1100);
  endtask

  task automatic test_random_frames(input int target);
    int          goal;
    int          n_pass;
    int          n_spr;
    int          pick;
    int unsigned depth_i;
    logic [15:0] n;
    logic [15:0] depth;
    logic [15:0] wx;
    logic [15:0] wy;
    logic [15:0] wa;
    goal = items_sent + target;
    while (items_sent < goal) begin
      if ($urandom_range(0, 3) != 0) frame_start();
      n_pass = $urandom_range(1, 3);
      repeat (n_pass) begin
        n = rand16();
        if (n[15:14] == 2'b00) pass_start(3'd0, 3'd7);
        else if (n[13:12] != 2'b00) pass_start(n[2:0], n[5:3]);
        n_spr = $urandom_range(1, 6);
        repeat (n_spr) begin
          if ($urandom_range(0, 11) == 0) sender_calm = !sender_calm;
          n = rand16();
          pick = $urandom_range(0, 15);
          if (pick == 0) begin
            send_beat(ACT_UNUSED, n[2:0], n[5:3], rand16(), rand16(), rand16(),
                      rand16(), rand16());
          end else begin
            if (pick == 1) begin
              depth = rand16();
            end else if (pick == 2) begin
              depth = 16'hFB00 + {6'd0, n[9:0]};
            end else begin
              depth_i = drawn_depth + $urandom_range(0, 64);
              depth = (depth_i > 65535) ? 16'hFFFF : depth_i[15:0];
            end
            wx = rand16();
            wy = rand16();
            wa = rand16();
            if (n[6]) wx[9:8] = 2'b00;
            if (n[7]) wy[9:7] = 3'b000;
            if (n[11:10] != 2'b11) wa[15:14] = 2'b00;
            if (n[12]) wa[11:10] = 2'b00;
            sprite(depth, wx, wy, rand16(), wa);
          end
        end
      end
    end
  endtask

  // output side: random stalls between beats, with calm stretches
  initial begin : drive_ready
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 23) == 0) receiver_calm = !receiver_calm;
      stall = receiver_calm ? 0 : $urandom_range(0, 8);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : check_rows
    tile_row_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rows.size() == 0) begin
        report("unexpected beat", 0, out_tdata);
      end else begin
        want = expected_rows.pop_front();
        compare_field("row_x", want.row_x, out_tdata[11:0]);
        compare_field("row_y", want.row_y, out_tdata[23:12]);
        compare_field("row_tile_base", want.tile_base, out_tdata[42:24]);
        compare_field("column_start", want.col_start, out_tdata[46:43]);
        compare_field("columns", want.columns, out_tdata[51:47]);
        compare_field("flip_x", want.flip_x, out_tdata[52]);
        compare_field("palette", want.palette, out_tdata[57:53]);
        compare_field("edge_care", want.edge_care, out_tdata[58]);
        compare_field("use_mask_draw", want.mask_draw, out_tdata[59]);
        compare_field("clear_depth", want.clear_depth, out_tuser);
        compare_field("last", want.row_last, out_tlast);
      end
    end
  end

  initial begin : run_tests
    logic [15:0] ra;
    logic [15:0] rb;
    logic [15:0] rc;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    obj_scroll_x = 10'd0;
    obj_scroll_y = 10'd0;
    level_mask = 8'hFF;
    pass_masked = 1'b0;
    pass_lo = 3'd0;
    pass_hi = 3'd7;
    drawn_depth = 16'd1;
    masked_depth = 16'd0;
    depth_offset = 16'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_depth_order();
    test_scroll_and_enable();

    set_config(10'd0, 10'd0, 8'hFF);
    test_random_frames(48);
    set_config(10'h3FF, 10'h3FF, 8'hFF);
    test_random_frames(48);
    ra = rand16();
    rb = rand16();
    rc = rand16();
    set_config(ra[9:0], rb[9:0], rc[7:0] | 8'h0F);
    test_random_frames(48);
    set_config(rb[9:0], ra[9:0], rc[15:8]);
    test_random_frames(48);

    wait_idle();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/stre_pkg.sv
rtl/core/stre_ctrl.sv
rtl/core/stre_dp.sv
rtl/core/sprite_to_tile_row_expander_unit.sv
rtl/core/stre_checker.sv
sim/testbench.sv
